>>> src/kpc_pkg.sv
// Package for the key press classifier: word types, phase codes and reset constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package kpc_pkg;

    localparam int PRESS_TICKS_W = 16;
    localparam int THRESH_W      = 16;

    localparam logic [THRESH_W-1:0] LONG_PRESS_TICKS_RESET = 16'd100;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_EDGE = 1'b1;

    localparam logic PIN_PRESSED = 1'b0;

    typedef struct packed {
        logic action;
        logic pin_level;
    } in_word_t;

    typedef struct packed {
        logic                     long_press;
        logic [PRESS_TICKS_W-1:0] press_ticks;
    } out_word_t;

    typedef struct packed {
        logic      emit;
        out_word_t word;
    } kpc_result_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_SETTLE  = 4'b0010,
        PH_HELD    = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

endpackage

>>> src/kpc_fsm.sv
// Debounce phase machine and held-tick counter of the key press classifier.
// Processes one input word per enabled cycle; depends on kpc_pkg.
`timescale 1ns / 1ps

module kpc_fsm
    import kpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  in_word_t            in_word,
    input  logic [THRESH_W-1:0] threshold,
    output kpc_result_t         result
);

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] held_count_reg, held_count_next;
    logic                   timer_active_reg, timer_active_next;
    logic                   edge_armed_reg, edge_armed_next;

    logic [CMP_W-1:0]         count_ext;
    logic [CMP_W-1:0]         thresh_ext;
    logic [PRESS_TICKS_W-1:0] ticks_sat;
    logic                     emit;

    assign count_ext  = CMP_W'(held_count_reg);
    assign thresh_ext = CMP_W'(threshold);

    generate
        if (COUNT_WIDTH > PRESS_TICKS_W) begin : g_sat
            assign ticks_sat = (|held_count_reg[COUNT_WIDTH-1:PRESS_TICKS_W])
                             ? {PRESS_TICKS_W{1'b1}}
                             : held_count_reg[PRESS_TICKS_W-1:0];
        end else begin : g_ext
            assign ticks_sat = PRESS_TICKS_W'(held_count_reg);
        end
    endgenerate

    always_comb begin
        phase_next        = phase_reg;
        held_count_next   = held_count_reg;
        timer_active_next = timer_active_reg;
        edge_armed_next   = edge_armed_reg;
        emit              = 1'b0;
        if (step_en) begin
            if (in_word.action == ACTION_EDGE) begin
                if (edge_armed_reg) begin
                    case (phase_reg)
                        PH_IDLE: begin
                            timer_active_next = 1'b1;
                            edge_armed_next   = 1'b0;
                            phase_next        = PH_SETTLE;
                        end
                        PH_HELD: begin
                            emit              = 1'b1;
                            held_count_next   = '0;
                            timer_active_next = 1'b1;
                            edge_armed_next   = 1'b0;
                            phase_next        = PH_RELEASE;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (timer_active_reg) begin
                case (phase_reg)
                    PH_SETTLE: begin
                        phase_next      = PH_HELD;
                        edge_armed_next = 1'b1;
                    end
                    PH_HELD: begin
                        if (in_word.pin_level == PIN_PRESSED) begin
                            if (held_count_reg != {COUNT_WIDTH{1'b1}}) begin
                                held_count_next = held_count_reg + COUNT_WIDTH'(1);
                            end
                        end else begin
                            timer_active_next = 1'b0;
                            held_count_next   = '0;
                            phase_next        = PH_IDLE;
                        end
                        edge_armed_next = 1'b1;
                    end
                    PH_RELEASE: begin
                        timer_active_next = 1'b0;
                        edge_armed_next   = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            held_count_reg   <= '0;
            timer_active_reg <= 1'b0;
            edge_armed_reg   <= 1'b1;
        end else begin
            phase_reg        <= phase_next;
            held_count_reg   <= held_count_next;
            timer_active_reg <= timer_active_next;
            edge_armed_reg   <= edge_armed_next;
        end
    end

    assign result.emit             = emit;
    assign result.word.long_press  = (count_ext >= thresh_ext);
    assign result.word.press_ticks = ticks_sat;

endmodule

>>> src/key_press_classifier.sv
// Top level of the key press classifier: input register, result register, threshold register.
// Instantiates kpc_fsm; depends on kpc_pkg.
`timescale 1ns / 1ps

// The block debounces an active-low push button and reports each press as short or long.
// Input words on s_valid/s_ready/s_data are either timer ticks carrying the sampled pin
// level or pin-edge events. Result words on m_valid/m_ready/m_data come out only on the
// release edge of a held press and carry the held tick count and the long flag.
// The user writes the threshold through cfg_wr_en/cfg_wr_data while the block is idle;
// the block itself does not enforce this. A word passes the input register, the phase
// machine and the result register. Throughput is one word per cycle while the receiver
// does not stall; the phase machine and the counter update with the result register.
// Most words produce no result and simply update the state.
// Reset returns the phase to idle, clears the count, stops the timer, arms edges, sets
// the threshold to 100 and empties both registers.
// When the receiver stalls, the result register holds its word and the input register
// still takes one more word; s_ready then drops until m_ready returns.
module key_press_classifier
    import kpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_word_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [THRESH_W-1:0] cfg_wr_data
);

    logic                in_valid_reg;
    in_word_t            in_word_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic                advance;
    kpc_result_t         result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    kpc_fsm #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .in_word   (in_word_reg),
        .threshold (thresh_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= LONG_PRESS_TICKS_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= result.emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance && result.emit) begin
            out_word_reg <= result.word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

>>> src/kpc_checker.sv
// Port-level checker for the key press classifier, bound to the top level.
// Depends on kpc_pkg and key_press_classifier.
`timescale 1ns / 1ps

module kpc_checker
    import kpc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    a_result_from_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.action == ACTION_EDGE, 2))
        else $error("result word without an accepted edge two cycles earlier");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result is pending");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tb_top.sv
// Self-checking testbench for key_press_classifier: press words in, release reports out.
// Holds its own model of the debounce phase machine; depends on kpc_pkg and the block.
`timescale 1ns / 1ps

module tb_top;
    import kpc_pkg::*;

    localparam logic PIN_RELEASED = ~PIN_PRESSED;
    localparam logic [PRESS_TICKS_W-1:0] TICKS_MAX = '1;
    localparam int WORD_BOUND = 2000;
    localparam int LIMIT_CYCLES = 4 * (WORD_BOUND * 48 + 5000);
    localparam int TAIL_CYCLES = 8;
    localparam int LONG_HOLD = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [THRESH_W-1:0] cfg_wr_data = '0;

    in_word_t words_pending[$];
    out_word_t press_reports_due[$];

    phase_t key_phase;
    logic [PRESS_TICKS_W-1:0] held_ticks;
    logic timer_running;
    logic edges_armed;
    logic [THRESH_W-1:0] long_thresh;

    bit report_due;
    out_word_t report_word;
    out_word_t due_word;

    int words_queued = 0;
    int words_accepted = 0;
    int reports_checked = 0;
    int mismatches = 0;
    int settings_used = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    bit quiet = 1'b0;
    bit pressure_on = 1'b0;
    bit pressure_done = 1'b0;

    key_press_classifier u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic void classify_word(input in_word_t w, output bit hit,
                                          output out_word_t rep);
        hit = 1'b0;
        rep = '0;
        if (w.action == ACTION_EDGE) begin
            if (edges_armed) begin
                if (key_phase == PH_IDLE) begin
                    timer_running = 1'b1;
                    edges_armed = 1'b0;
                    key_phase = PH_SETTLE;
                end else if (key_phase == PH_HELD) begin
                    hit = 1'b1;
                    rep.long_press = (held_ticks >= long_thresh);
                    rep.press_ticks = held_ticks;
                    held_ticks = '0;
                    timer_running = 1'b1;
                    edges_armed = 1'b0;
                    key_phase = PH_RELEASE;
                end
            end
        end else if (timer_running) begin
            case (key_phase)
                PH_SETTLE: begin
                    key_phase = PH_HELD;
                    edges_armed = 1'b1;
                end
                PH_HELD: begin
                    if (w.pin_level == PIN_PRESSED) begin
                        if (held_ticks != TICKS_MAX)
                            held_ticks = held_ticks + PRESS_TICKS_W'(1);
                    end else begin
                        timer_running = 1'b0;
                        held_ticks = '0;
                        key_phase = PH_IDLE;
                    end
                    edges_armed = 1'b1;
                end
                PH_RELEASE: begin
                    timer_running = 1'b0;
                    edges_armed = 1'b1;
                    key_phase = PH_IDLE;
                end
                default: ;
            endcase
        end
    endfunction

    task automatic flag_mismatch(input string what, input out_word_t e, input out_word_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected long=%0d ticks=%0d, got long=%0d ticks=%0d",
                     what, e.long_press, e.press_ticks, a.long_press, a.press_ticks);
    endtask

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic add_word(input logic act, input logic pin);
        in_word_t w;
        w.action = act;
        w.pin_level = pin;
        words_pending.push_back(w);
        words_queued++;
    endtask

    task automatic add_press(input int n_low, input bit bounce);
        add_word(ACTION_EDGE, coin());
        add_word(ACTION_TICK, coin());
        repeat (n_low) add_word(ACTION_TICK, PIN_PRESSED);
        if (bounce) begin
            add_word(ACTION_TICK, PIN_RELEASED);
        end else begin
            add_word(ACTION_EDGE, coin());
            add_word(ACTION_TICK, coin());
        end
    endtask

    task automatic gen_traffic(input int n_words, input int max_low);
        int start_cnt;
        int pick;
        int n;
        start_cnt = words_queued;
        while (words_queued - start_cnt < n_words) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                add_press($urandom_range(0, max_low), pick == 0);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) add_word(coin(), coin());
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (words_pending.size() != 0 || s_valid || press_reports_due.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        long_thresh = v;
        settings_used++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (words_pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 19) - 1;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data <= words_pending.pop_front();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                classify_word(s_data, report_due, report_word);
                words_accepted++;
                if (report_due)
                    press_reports_due.push_back(report_word);
            end
            if (m_valid && m_ready) begin
                if (press_reports_due.size() == 0) begin
                    flag_mismatch("result with nothing expected", '0, m_data);
                end else begin
                    due_word = press_reports_due.pop_front();
                    reports_checked++;
                    if (due_word.long_press !== m_data.long_press ||
                        due_word.press_ticks !== m_data.press_ticks)
                        flag_mismatch("wrong result", due_word, m_data);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (pressure_on && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 19) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        key_phase = PH_IDLE;
        held_ticks = '0;
        timer_running = 1'b0;
        edges_armed = 1'b1;
        long_thresh = LONG_PRESS_TICKS_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Ignored ticks, a disarmed edge, a short press, a bounce and an empty press.
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_RELEASED);
        add_word(ACTION_EDGE, PIN_PRESSED);
        add_word(ACTION_EDGE, PIN_RELEASED);
        add_word(ACTION_TICK, PIN_RELEASED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_EDGE, PIN_RELEASED);
        add_word(ACTION_EDGE, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_EDGE, PIN_RELEASED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_RELEASED);
        add_word(ACTION_EDGE, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_PRESSED);
        add_word(ACTION_EDGE, PIN_PRESSED);
        add_word(ACTION_TICK, PIN_RELEASED);
        gen_traffic(200, 130);
        wait_drained();

        set_threshold('0);
        gen_traffic(150, 5);
        wait_drained();

        set_threshold(TICKS_MAX);
        add_press(40, 1'b0);
        add_press(3, 1'b0);
        wait_drained();

        set_threshold(16'd1);
        gen_traffic(150, 3);
        wait_drained();

        repeat (3) begin
            set_threshold(16'($urandom_range(0, 30)));
            gen_traffic(200, 40);
            wait_drained();
        end

        set_threshold(16'd2);
        gen_traffic(150, 3);
        pressure_on = 1'b1;
        wait_drained();

        quiet = 1'b1;
        set_threshold(16'($urandom_range(0, 20)));
        gen_traffic(150, 25);
        wait_drained();

        mismatches += press_reports_due.size();
        $display("summary: %0d input words accepted, %0d press reports checked, %0d mismatches",
                 words_accepted, reports_checked, mismatches);
        $display("summary: %0d threshold settings and one long receiver stall",
                 settings_used);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
